>>> hw/rtl/dab_pkg.sv
package dab_pkg;

   localparam int unsigned MINUTES_PER_HOUR = 60;

   localparam logic [2:0] MODE_TICK        = 3'd0;
   localparam logic [2:0] MODE_SET         = 3'd1;
   localparam logic [2:0] MODE_DISABLE     = 3'd2;
   localparam logic [2:0] MODE_DISABLE_ALL = 3'd3;
   localparam logic [2:0] MODE_CLEAR       = 3'd4;
   localparam logic [2:0] MODE_QUERY       = 3'd5;

   localparam logic CSR_RING_WINDOW = 1'b0;
   localparam logic CSR_BLANKING    = 1'b1;

   typedef struct packed {
      logic [2:0] mode;
      logic [3:0] alarm_index;
      logic [4:0] set_hour;
      logic [5:0] set_minute;
      logic [4:0] now_hour;
      logic [5:0] now_minute;
   } req_type;

   typedef struct packed {
      logic       any_ringing;
      logic [2:0] ringing_index;
      logic [4:0] sel_hour;
      logic [5:0] sel_minute;
      logic       sel_enabled;
      logic       sel_ringing;
   } rsp_type;

   typedef struct packed {
      logic [10:0] ring_window_minutes;
      logic [10:0] blanking_minutes;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic [2:0]  mode;
      logic [3:0]  alarm_index;
      logic [4:0]  set_hour;
      logic [5:0]  set_minute;
      logic [10:0] now_mod;
      rsp_type     rsp;
   } token_type;

   function automatic logic [10:0] minute_of_day(input logic [4:0] hour,
                                                 input logic [5:0] minute);
      minute_of_day = 11'(11'(hour) * 11'(MINUTES_PER_HOUR)) + 11'(minute);
   endfunction

endpackage

>>> hw/rtl/daily_alarm_bank.sv
// Bank of NUM_ALARMS daily alarms matched against the time of day.
// A command word is taken at a rising edge where start is high and busy is low.
// The mode field selects tick, set alarm, disable one, disable all, clear
// ringing or query; unused modes act as a query.
// Each alarm lives in one cell of a chain, and the command travels down the
// chain one cell per cycle, each cell applying it to its own alarm and adding
// its contribution to the result word that rides along with it.
// The result word appears on rsp_word for exactly one cycle with rsp_valid
// high, once the command has passed the input register and every cell, and
// the receiver cannot stall it.
// Busy stays high from the accepting edge until the result cycle, so a new
// command is taken only after the last one has walked through the chain.
// The APB port holds the ring window at address 0 and the blanking time at
// address 4; write them only while busy is low.
// Reset disables and clears all alarms and reloads a window of 5 minutes and a
// blanking time of 60 minutes.
module daily_alarm_bank #(
   parameter int NUM_ALARMS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dab_pkg::req_type req_word,
   output logic             rsp_valid,
   output dab_pkg::rsp_type rsp_word,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   dab_pkg::cfg_type   cfg_ff, cfg_in;
   dab_pkg::token_type cmd_ff, cmd_in;
   dab_pkg::token_type chain [NUM_ALARMS + 1];
   logic [NUM_ALARMS-1:0] in_flight;
   logic csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (paddr[2])
            dab_pkg::CSR_RING_WINDOW: cfg_in.ring_window_minutes = pwdata[10:0];
            dab_pkg::CSR_BLANKING:    cfg_in.blanking_minutes    = pwdata[10:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         dab_pkg::CSR_RING_WINDOW: prdata = {21'd0, cfg_ff.ring_window_minutes};
         dab_pkg::CSR_BLANKING:    prdata = {21'd0, cfg_ff.blanking_minutes};
         default:                  prdata = '0;
      endcase
   end

   always_comb begin
      cmd_in             = '0;
      cmd_in.valid       = start && !busy;
      cmd_in.mode        = req_word.mode;
      cmd_in.alarm_index = req_word.alarm_index;
      cmd_in.set_hour    = req_word.set_hour;
      cmd_in.set_minute  = req_word.set_minute;
      cmd_in.now_mod     = dab_pkg::minute_of_day(req_word.now_hour, req_word.now_minute);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ring_window_minutes <= 11'd5;
         cfg_ff.blanking_minutes    <= 11'd60;
         cmd_ff                     <= '0;
      end else begin
         cfg_ff <= cfg_in;
         cmd_ff <= cmd_in;
      end
   end

   assign chain[0] = cmd_ff;

   for (genvar i = 0; i < NUM_ALARMS; i++) begin : g_cell
      dab_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .cfg    (cfg_ff),
         .tok_in (chain[i]),
         .tok_out(chain[i+1])
      );
      assign in_flight[i] = chain[i].valid;
   end

   assign busy      = |in_flight;
   assign rsp_valid = chain[NUM_ALARMS].valid;
   assign rsp_word  = chain[NUM_ALARMS].rsp;

endmodule

>>> hw/rtl/dab_cell.sv
module dab_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  dab_pkg::cfg_type   cfg,
   input  dab_pkg::token_type tok_in,
   output dab_pkg::token_type tok_out
);

   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic        enabled_ff, enabled_in;
   logic        ringing_ff, ringing_in;
   logic [10:0] cleared_ff, cleared_in;
   dab_pkg::token_type tok_ff, tok_in_next;

   logic [10:0] alarm_mod;
   logic [11:0] window_end;
   logic [11:0] blank_end;
   logic        hit;
   logic        can_ring;

   assign hit        = tok_in.alarm_index == 4'(CELL_INDEX);
   assign alarm_mod  = dab_pkg::minute_of_day(hour_ff, minute_ff);
   assign window_end = {1'b0, alarm_mod} + {1'b0, cfg.ring_window_minutes};
   assign blank_end  = {1'b0, cleared_ff} + {1'b0, cfg.blanking_minutes};
   assign can_ring   = enabled_ff && !ringing_ff && (tok_in.now_mod >= alarm_mod)
                       && ({1'b0, tok_in.now_mod} < window_end)
                       && ({1'b0, tok_in.now_mod} >= blank_end);

   always_comb begin
      hour_in     = hour_ff;
      minute_in   = minute_ff;
      enabled_in  = enabled_ff;
      ringing_in  = ringing_ff;
      cleared_in  = cleared_ff;
      if (tok_in.valid) begin
         case (tok_in.mode)
            dab_pkg::MODE_TICK: begin
               if (can_ring) begin
                  ringing_in = 1'b1;
               end
            end
            dab_pkg::MODE_SET: begin
               if (hit) begin
                  hour_in    = tok_in.set_hour;
                  minute_in  = tok_in.set_minute;
                  enabled_in = 1'b1;
                  ringing_in = 1'b0;
               end
            end
            dab_pkg::MODE_DISABLE: begin
               if (hit) begin
                  enabled_in = 1'b0;
               end
            end
            dab_pkg::MODE_DISABLE_ALL: begin
               enabled_in = 1'b0;
            end
            dab_pkg::MODE_CLEAR: begin
               if (hit) begin
                  ringing_in = 1'b0;
                  cleared_in = tok_in.now_mod;
               end
            end
            default: begin
            end
         endcase
      end

      tok_in_next = tok_in;
      if (!tok_in.rsp.any_ringing && ringing_in) begin
         tok_in_next.rsp.any_ringing   = 1'b1;
         tok_in_next.rsp.ringing_index = 3'(CELL_INDEX);
      end
      if (hit) begin
         tok_in_next.rsp.sel_hour    = hour_in;
         tok_in_next.rsp.sel_minute  = minute_in;
         tok_in_next.rsp.sel_enabled = enabled_in;
         tok_in_next.rsp.sel_ringing = ringing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_ff    <= '0;
         minute_ff  <= '0;
         enabled_ff <= 1'b0;
         ringing_ff <= 1'b0;
         cleared_ff <= '0;
         tok_ff     <= '0;
      end else begin
         hour_ff    <= hour_in;
         minute_ff  <= minute_in;
         enabled_ff <= enabled_in;
         ringing_ff <= ringing_in;
         cleared_ff <= cleared_in;
         tok_ff     <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

>>> hw/rtl/dab_checker.sv
module dab_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input dab_pkg::rsp_type rsp_word
);

   // A command that is taken keeps the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted command did not raise busy");

   // Only one command is in flight, so results never come back to back.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");

   // The block is free again in the cycle that shows the result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy while the result is shown");

   // With no alarm ringing, the reported index is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.any_ringing |-> rsp_word.ringing_index == 3'd0)
      else $error("ringing index set while nothing rings");

   // Reset empties the chain.
   assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind daily_alarm_bank dab_checker u_dab_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .rsp_valid(rsp_valid),
   .rsp_word (rsp_word)
);
